### design/body_rate_torque_law_defines.svh
// Assertion macros shared by the body rate torque law RTL.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef BODY_RATE_TORQUE_LAW_DEFINES_SVH
`define BODY_RATE_TORQUE_LAW_DEFINES_SVH

// Condition now implies consequence in the same cycle.
`define BRTL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition now implies consequence in the next cycle.
`define BRTL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/brtl_pkg.sv
// Shared types, widths and register indexes for the body rate torque law.
// No dependencies.
package brtl_pkg;

  localparam int RateFracBits = 16;

  localparam int DataW      = 24;
  localparam int GainW      = 24;
  localparam int InertW     = 24;
  localparam int ErrW       = DataW + 1;
  localparam int KProdW     = ErrW + GainW + 1;
  localparam int KW         = KProdW - 16;
  localparam int VecW       = KW + 1;
  localparam int ProdW      = InertW + VecW;
  localparam int SumW       = ProdW + 2;
  localparam int JaW        = 34;
  localparam int CrossW     = DataW + JaW;
  localparam int CrossDiffW = CrossW + 1;
  localparam int GyroW      = CrossDiffW - (RateFracBits - 4);
  localparam int JuW        = SumW - 12;
  localparam int AccW       = 64;
  localparam int TorqueW    = 32;
  localparam int CfgAddrW   = 4;
  localparam int CfgDataW   = 24;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [VecW-1:0]  vec_t;
  typedef logic signed [SumW-1:0]  sum_t;

  typedef struct packed {
    logic signed [InertW-1:0] xx;
    logic signed [InertW-1:0] yy;
    logic signed [InertW-1:0] zz;
    logic signed [InertW-1:0] xy;
    logic signed [InertW-1:0] xz;
    logic signed [InertW-1:0] yz;
  } inertia_t;

  localparam logic [CfgAddrW-1:0] RegMode     = 4'd0;
  localparam logic [CfgAddrW-1:0] RegRateGain = 4'd1;
  localparam logic [CfgAddrW-1:0] RegInertXx  = 4'd2;
  localparam logic [CfgAddrW-1:0] RegInertYy  = 4'd3;
  localparam logic [CfgAddrW-1:0] RegInertZz  = 4'd4;
  localparam logic [CfgAddrW-1:0] RegInertXy  = 4'd5;
  localparam logic [CfgAddrW-1:0] RegInertXz  = 4'd6;
  localparam logic [CfgAddrW-1:0] RegInertYz  = 4'd7;

endpackage

### design/brtl_matvec.sv
// Two-stage symmetric 3x3 inertia times vector: products, then row sums.
// Depends on brtl_pkg.
module brtl_matvec import brtl_pkg::*; (
  input  logic     clk_i,
  input  inertia_t inertia_i,
  input  vec_t     vec_i [3],
  output sum_t     sum_o [3]
);

  logic signed [InertW-1:0] jm [3][3];
  logic signed [ProdW-1:0]  prod_q [3][3];
  sum_t                     sum_q [3];

  always_comb begin
    jm[0][0] = inertia_i.xx;
    jm[1][1] = inertia_i.yy;
    jm[2][2] = inertia_i.zz;
    jm[0][1] = inertia_i.xy;
    jm[1][0] = inertia_i.xy;
    jm[0][2] = inertia_i.xz;
    jm[2][0] = inertia_i.xz;
    jm[1][2] = inertia_i.yz;
    jm[2][1] = inertia_i.yz;
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[r][c] <= ProdW'(jm[r][c]) * ProdW'(vec_i[c]);
      end
      sum_q[r] <= SumW'(prod_q[r][0]) + SumW'(prod_q[r][1]) + SumW'(prod_q[r][2]);
    end
  end

  assign sum_o = sum_q;

endmodule

### design/body_rate_torque_law.sv
// Body rate torque law, top level: config registers and 8-stage datapath.
// Depends on brtl_pkg, brtl_matvec and body_rate_torque_law_defines.svh.
//
//  channel  | signals                                   | transaction
//  ---------+-------------------------------------------+---------------------------
//  config   | cfg_we_i, cfg_addr_i, cfg_wdata_i         | write at edge with cfg_we_i
//  command  | start_i, busy_o, rate_*, ref_rate_*, feed_* | edge with start_i && !busy_o
//  result   | done_o, torque_x/y/z_o, clipped_o         | one-cycle strobe on done_o
//
// One item enters every cycle; busy_o stays low, the pipeline never stalls.
// done_o is vld_q[7], the end of the valid chain that an accepted item enters at vld_q[0].
// Depth is set by the J*w and J*wr inertia multiplies in series with the cross
// products (multiply stage, sum stage, round stage each).
// Reset clears the valid chain, mode and inertia and sets the gain to 65536; data regs are not reset.
// Config writes must wait until the pipeline has drained.
`include "body_rate_torque_law_defines.svh"
module body_rate_torque_law import brtl_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgAddrW-1:0]        cfg_addr_i,
  input  logic [CfgDataW-1:0]        cfg_wdata_i,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic signed [DataW-1:0]    rate_x_i,
  input  logic signed [DataW-1:0]    rate_y_i,
  input  logic signed [DataW-1:0]    rate_z_i,
  input  logic signed [DataW-1:0]    ref_rate_x_i,
  input  logic signed [DataW-1:0]    ref_rate_y_i,
  input  logic signed [DataW-1:0]    ref_rate_z_i,
  input  logic signed [DataW-1:0]    feed_x_i,
  input  logic signed [DataW-1:0]    feed_y_i,
  input  logic signed [DataW-1:0]    feed_z_i,
  output logic                       done_o,
  output logic signed [TorqueW-1:0]  torque_x_o,
  output logic signed [TorqueW-1:0]  torque_y_o,
  output logic signed [TorqueW-1:0]  torque_z_o,
  output logic                       clipped_o
);

  // Round-half-up biases: (1 << s) >> 1 is zero when s is zero.
  localparam logic signed [KProdW-1:0]     KBias  = KProdW'(1) << 15;
  localparam logic signed [SumW-1:0]       JaBias = SumW'(1) << 15;
  localparam logic signed [SumW-1:0]       JuBias = SumW'(1) << 11;
  localparam logic signed [CrossDiffW-1:0] GBias  =
    (CrossDiffW'(1) << (RateFracBits - 4)) >> 1;
  localparam logic signed [AccW-1:0]       TBias  =
    (AccW'(1) << (RateFracBits - 8)) >> 1;

  // ---------------- configuration ----------------
  logic            mode_q;
  logic [GainW-1:0] gain_q;
  inertia_t        inertia_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      gain_q    <= GainW'(65536);
      inertia_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegMode:     mode_q       <= cfg_wdata_i[0];
        RegRateGain: gain_q       <= cfg_wdata_i[GainW-1:0];
        RegInertXx:  inertia_q.xx <= cfg_wdata_i[InertW-1:0];
        RegInertYy:  inertia_q.yy <= cfg_wdata_i[InertW-1:0];
        RegInertZz:  inertia_q.zz <= cfg_wdata_i[InertW-1:0];
        RegInertXy:  inertia_q.xy <= cfg_wdata_i[InertW-1:0];
        RegInertXz:  inertia_q.xz <= cfg_wdata_i[InertW-1:0];
        RegInertYz:  inertia_q.yz <= cfg_wdata_i[InertW-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------- valid chain ----------------
  logic       accept;
  logic [7:0] vld_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[6:0], accept};
    end
  end

  // ---------------- datapath registers ----------------
  data_t w1_q [3], wr1_q [3], f1_q [3];
  logic signed [ErrW-1:0] e1_q [3];
  data_t w2_q [3], wr2_q [3], f2_q [3];
  logic signed [KProdW-1:0] kprod2_q [3];
  data_t w3_q [3], wr3_q [3], f3_q [3];
  logic signed [KW-1:0] k3_q [3];
  data_t w4_q [3], wr4_q [3], f4_q [3];
  logic signed [JaW-1:0] ja4_q [3], jr4_q [3];
  vec_t  v4_q [3];
  data_t f5_q [3], f6_q [3], f7_q [3];
  logic signed [CrossW-1:0] pw5_q [3][2], pr5_q [3][2];
  logic signed [CrossDiffW-1:0] tw6_q [3], tr6_q [3];
  logic signed [GyroW-1:0] gw7_q [3], gr7_q [3];
  logic signed [JuW-1:0] ju7_q [3];

  vec_t w1_ext [3], wr1_ext [3];
  sum_t sum_w [3], sum_wr [3], sum_v [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w1_ext[i]  = VecW'(w1_q[i]);
      wr1_ext[i] = VecW'(wr1_q[i]);
    end
  end

  // J*w and J*wr: products in stage 2, sums in stage 3
  brtl_matvec u_mv_rate (
    .clk_i, .inertia_i(inertia_q), .vec_i(w1_ext), .sum_o(sum_w)
  );
  brtl_matvec u_mv_ref (
    .clk_i, .inertia_i(inertia_q), .vec_i(wr1_ext), .sum_o(sum_wr)
  );
  // J*k (torque mode) or J*(f-k): products in stage 5, sums in stage 6
  brtl_matvec u_mv_cmd (
    .clk_i, .inertia_i(inertia_q), .vec_i(v4_q), .sum_o(sum_v)
  );

  always_ff @(posedge clk_i) begin
    // stage 1: capture, rate error
    w1_q[0]  <= rate_x_i;      w1_q[1]  <= rate_y_i;      w1_q[2]  <= rate_z_i;
    wr1_q[0] <= ref_rate_x_i;  wr1_q[1] <= ref_rate_y_i;  wr1_q[2] <= ref_rate_z_i;
    f1_q[0]  <= feed_x_i;      f1_q[1]  <= feed_y_i;      f1_q[2]  <= feed_z_i;
    e1_q[0]  <= ErrW'(rate_x_i) - ErrW'(ref_rate_x_i);
    e1_q[1]  <= ErrW'(rate_y_i) - ErrW'(ref_rate_y_i);
    e1_q[2]  <= ErrW'(rate_z_i) - ErrW'(ref_rate_z_i);
    for (int i = 0; i < 3; i++) begin
      // stage 2: gain product
      kprod2_q[i] <= KProdW'($signed({1'b0, gain_q})) * KProdW'(e1_q[i]);
      w2_q[i] <= w1_q[i];  wr2_q[i] <= wr1_q[i];  f2_q[i] <= f1_q[i];
      // stage 3: round gain term to rate format
      k3_q[i] <= KW'((kprod2_q[i] + KBias) >>> 16);
      w3_q[i] <= w2_q[i];  wr3_q[i] <= wr2_q[i];  f3_q[i] <= f2_q[i];
      // stage 4: round J*w, J*wr; pick the vector for the command product
      ja4_q[i] <= JaW'((sum_w[i] + JaBias) >>> 16);
      jr4_q[i] <= JaW'((sum_wr[i] + JaBias) >>> 16);
      v4_q[i]  <= mode_q ? VecW'(f3_q[i]) - VecW'(k3_q[i]) : VecW'(k3_q[i]);
      w4_q[i] <= w3_q[i];  wr4_q[i] <= wr3_q[i];  f4_q[i] <= f3_q[i];
      // stage 5: cross product terms, a[i+1]*ja[i+2] and a[i+2]*ja[i+1]
      pw5_q[i][0] <= CrossW'(w4_q[(i+1)%3]) * CrossW'(ja4_q[(i+2)%3]);
      pw5_q[i][1] <= CrossW'(w4_q[(i+2)%3]) * CrossW'(ja4_q[(i+1)%3]);
      pr5_q[i][0] <= CrossW'(wr4_q[(i+1)%3]) * CrossW'(jr4_q[(i+2)%3]);
      pr5_q[i][1] <= CrossW'(wr4_q[(i+2)%3]) * CrossW'(jr4_q[(i+1)%3]);
      f5_q[i] <= f4_q[i];
      // stage 6: cross product differences
      tw6_q[i] <= CrossDiffW'(pw5_q[i][0]) - CrossDiffW'(pw5_q[i][1]);
      tr6_q[i] <= CrossDiffW'(pr5_q[i][0]) - CrossDiffW'(pr5_q[i][1]);
      f6_q[i] <= f5_q[i];
      // stage 7: round gyro terms and command product to Q(F+8)
      gw7_q[i] <= GyroW'((tw6_q[i] + GBias) >>> (RateFracBits - 4));
      gr7_q[i] <= GyroW'((tr6_q[i] + GBias) >>> (RateFracBits - 4));
      ju7_q[i] <= JuW'((sum_v[i] + JuBias) >>> 12);
      f7_q[i] <= f6_q[i];
    end
  end

  // ---------------- stage 8: sum, round to Q16.16, saturate ----------------
  logic signed [AccW-1:0]    acc [3];
  logic signed [AccW-1:0]    rnd [3];
  logic signed [TorqueW-1:0] sat [3];
  logic [2:0]                clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (mode_q) begin
        acc[i] = AccW'(ju7_q[i]) + AccW'(gw7_q[i]);
      end else begin
        acc[i] = AccW'(gw7_q[i]) - AccW'(ju7_q[i]) - AccW'(gr7_q[i])
                 + (AccW'(f7_q[i]) <<< 8);
      end
      rnd[i] = (acc[i] + TBias) >>> (RateFracBits - 8);
      priority if (!rnd[i][AccW-1] && (|rnd[i][AccW-2:TorqueW-1])) begin
        sat[i]  = {1'b0, {(TorqueW-1){1'b1}}};
        clip[i] = 1'b1;
      end else if (rnd[i][AccW-1] && !(&rnd[i][AccW-2:TorqueW-1])) begin
        sat[i]  = {1'b1, {(TorqueW-1){1'b0}}};
        clip[i] = 1'b1;
      end else begin
        sat[i]  = rnd[i][TorqueW-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  logic signed [TorqueW-1:0] tq_q [3];
  logic                      clip_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      tq_q[i] <= sat[i];
    end
    clip_q <= |clip;
  end

  assign done_o     = vld_q[7];
  assign torque_x_o = tq_q[0];
  assign torque_y_o = tq_q[1];
  assign torque_z_o = tq_q[2];
  assign clipped_o  = clip_q;

  // ---------------- assertions ----------------
  `BRTL_ASSERT_IMP(a_done_latency, done_o, $past(accept, 8),
                   "result without a command eight cycles earlier")
  `BRTL_ASSERT_IMP(a_clip_at_rail, done_o && clipped_o,
                   torque_x_o == 32'sh7fffffff || torque_x_o == 32'sh80000000 ||
                   torque_y_o == 32'sh7fffffff || torque_y_o == 32'sh80000000 ||
                   torque_z_o == 32'sh7fffffff || torque_z_o == 32'sh80000000,
                   "clipped set with no torque at a rail")
  `BRTL_ASSERT_NXT(a_valid_shift, accept, vld_q[0],
                   "accepted command did not enter the pipeline")

endmodule
